>>> sv/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg
// Shared types and constants of the edit distance engine: item kinds, field
// widths, default capacities and the command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package ede_pkg;

	localparam int KIND_W = 2;
	localparam int SYM_W  = 8;
	localparam int DIST_W = 7;

	localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

	localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

	localparam int MAX_FIRST_DEF  = 64;
	localparam int MAX_SECOND_DEF = 64;

	typedef struct packed {
		logic wr_first;
		logic wr_second;
		logic start;
		logic row_start;
		logic cell_step;
		logic finish;
	} ede_cmd_t;

	typedef struct packed {
		logic empty;
		logic col_last;
		logic row_last;
	} ede_stat_t;

endpackage

`default_nettype wire

>>> sv/ede_if.sv
// ----------------------------------------------------------------------------
// ede_if
// Valid/ready channels of the edit distance engine: one for input items and
// one for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ede_in_if;
	import ede_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SYM_W-1:0]  symbol;

	modport source (output valid, output kind, output symbol, input ready);
	modport sink (input valid, input kind, input symbol, output ready);
endinterface

interface ede_out_if;
	import ede_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              overflow;

	modport source (output valid, output distance, output overflow, input ready);
	modport sink (input valid, input distance, input overflow, output ready);
endinterface

`default_nettype wire

>>> sv/ede_ctrl.sv
// ----------------------------------------------------------------------------
// ede_ctrl
// Controller of the edit distance engine: accepts items, sequences the row
// and cell steps of a run and owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [ede_pkg::KIND_W-1:0] kind,
	output logic                           in_ready,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	input  wire ede_pkg::ede_stat_t        stat,
	output ede_pkg::ede_cmd_t              cmd
);
	import ede_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROW   = 3'd1;
	localparam logic [2:0] ST_CELL  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.wr_first  = accept && (kind == KIND_FIRST);
		cmd.wr_second = accept && (kind == KIND_SECOND);
		cmd.start     = accept && (kind == KIND_RUN);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					state_d = stat.empty ? ST_DONE : ST_ROW;
				end
			end
			ST_ROW: begin
				cmd.row_start = 1'b1;
				state_d       = ST_CELL;
			end
			ST_CELL: begin
				cmd.cell_step = 1'b1;
				if (stat.col_last) begin
					state_d = stat.row_last ? ST_DRAIN : ST_ROW;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/ede_dp.sv
// ----------------------------------------------------------------------------
// ede_dp
// Datapath of the edit distance engine: string stores, cost row store,
// row and column counters, the cell pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_dp #(
	parameter int MAX_FIRST  = ede_pkg::MAX_FIRST_DEF,
	parameter int MAX_SECOND = ede_pkg::MAX_SECOND_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ede_pkg::ede_cmd_t         cmd,
	input  wire logic [ede_pkg::SYM_W-1:0] symbol,
	output ede_pkg::ede_stat_t             stat,
	output logic [ede_pkg::DIST_W-1:0]     distance,
	output logic                           overflow
);
	import ede_pkg::*;

	localparam int AW1  = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;
	localparam int AW2  = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
	localparam int CW1  = $clog2(MAX_FIRST + 1);
	localparam int CW2  = $clog2(MAX_SECOND + 1);
	localparam int MAXV = (MAX_FIRST > MAX_SECOND) ? MAX_FIRST : MAX_SECOND;
	localparam int VW   = $clog2(MAXV + 1);
	localparam int SW   = (VW + 1 > DIST_W + 1) ? VW + 1 : DIST_W + 1;

	logic [SYM_W-1:0] first_mem [MAX_FIRST];
	logic [SYM_W-1:0] second_mem [MAX_SECOND];
	logic [VW-1:0]    cost_mem [MAX_SECOND];

	logic [CW1-1:0]    cnt1_q;
	logic [CW2-1:0]    cnt2_q;
	logic              ovf_q;
	logic [CW1-1:0]    n1_q;
	logic [CW2-1:0]    n2_q;
	logic              run_ovf_q;
	logic [CW1-1:0]    r_q;
	logic [CW2-1:0]    c_q;
	logic              valid_s1;
	logic [SYM_W-1:0]  a_s1;
	logic [SYM_W-1:0]  b_s1;
	logic [VW-1:0]     above_s1;
	logic [CW2-1:0]    col_s1;
	logic              top_s1;
	logic [VW-1:0]     left_q;
	logic [VW-1:0]     diag_q;
	logic [VW-1:0]     res_q;
	logic [DIST_W-1:0] dist_q;
	logic              ovf_out_q;

	logic           wr1;
	logic           wr2;
	logic [CW1-1:0] r_m1;
	logic [CW2-1:0] c_m1;
	logic [CW2-1:0] col_m1;
	logic [VW-1:0]  above;
	logic [VW-1:0]  mn;
	logic [VW-1:0]  cell_cost;
	logic           empty_run;
	logic [SW-1:0]  fin;

	assign wr1    = cmd.wr_first && (cnt1_q < CW1'(MAX_FIRST));
	assign wr2    = cmd.wr_second && (cnt2_q < CW2'(MAX_SECOND));
	assign r_m1   = r_q - CW1'(1);
	assign c_m1   = c_q - CW2'(1);
	assign col_m1 = col_s1 - CW2'(1);

	assign stat.empty    = (cnt1_q == '0) || (cnt2_q == '0);
	assign stat.col_last = (c_q == n2_q);
	assign stat.row_last = (r_q == n1_q);

	// cell of the cost matrix
	always_comb begin
		above = top_s1 ? VW'(col_s1) : above_s1;
		mn    = (above < left_q) ? above : left_q;
		if (diag_q < mn) begin
			mn = diag_q;
		end
		cell_cost = (a_s1 == b_s1) ? diag_q : VW'(mn + VW'(1));
	end

	assign empty_run = (n1_q == '0) || (n2_q == '0);
	assign fin       = empty_run ? (SW'(n1_q) + SW'(n2_q)) : SW'(res_q);

	always_ff @(posedge clk) begin
		if (wr1) begin
			first_mem[cnt1_q[AW1-1:0]] <= symbol;
		end
		if (cmd.row_start) begin
			a_s1 <= first_mem[r_m1[AW1-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr2) begin
			second_mem[cnt2_q[AW2-1:0]] <= symbol;
		end
		if (cmd.cell_step) begin
			b_s1 <= second_mem[c_m1[AW2-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cost_mem[col_m1[AW2-1:0]] <= cell_cost;
		end
		if (cmd.cell_step) begin
			above_s1 <= cost_mem[c_m1[AW2-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q    <= '0;
			cnt2_q    <= '0;
			ovf_q     <= 1'b0;
			n1_q      <= '0;
			n2_q      <= '0;
			run_ovf_q <= 1'b0;
			r_q       <= '0;
			c_q       <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= cmd.cell_step;
			if (cmd.start) begin
				n1_q      <= cnt1_q;
				n2_q      <= cnt2_q;
				run_ovf_q <= ovf_q;
				cnt1_q    <= '0;
				cnt2_q    <= '0;
				ovf_q     <= 1'b0;
				r_q       <= CW1'(1);
			end else begin
				if (cmd.wr_first) begin
					if (wr1) begin
						cnt1_q <= cnt1_q + CW1'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				if (cmd.wr_second) begin
					if (wr2) begin
						cnt2_q <= cnt2_q + CW2'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (cmd.row_start) begin
				c_q <= CW2'(1);
			end else if (cmd.cell_step) begin
				c_q <= c_q + CW2'(1);
				if (stat.col_last) begin
					r_q <= r_q + CW1'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cell_step) begin
			col_s1 <= c_q;
			top_s1 <= (r_q == CW1'(1));
		end
		if (valid_s1) begin
			res_q <= cell_cost;
		end
		// new row takes precedence over the last cell of the previous row
		if (cmd.row_start) begin
			left_q <= VW'(r_q);
			diag_q <= VW'(r_m1);
		end else if (valid_s1) begin
			left_q <= cell_cost;
			diag_q <= above;
		end
		if (cmd.finish) begin
			dist_q    <= (fin > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(fin);
			ovf_out_q <= run_ovf_q;
		end
	end

	assign distance = dist_q;
	assign overflow = ovf_out_q;

endmodule

`default_nettype wire

>>> sv/edit_distance_engine_unit.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_unit
// Levenshtein edit distance engine: loads two byte strings item by item and
// returns their distance and an overflow flag on a run item.
// ----------------------------------------------------------------------------
// append items are accepted only while the engine is idle
// run item: result comes from the matrix rows, or straight from the string lengths if a string is empty
// each row has one setup step, then one step per matrix cell
// appends are accepted while a previous result is still waiting on the output
// reset clears counters, flags and handshake state; string and row stores are not cleared
`default_nettype none

module edit_distance_engine_unit #(
	parameter int MAX_FIRST  = ede_pkg::MAX_FIRST_DEF,
	parameter int MAX_SECOND = ede_pkg::MAX_SECOND_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ede_in_if.sink     item,
	ede_out_if.source  result
);
	import ede_pkg::*;

	ede_cmd_t  cmd;
	ede_stat_t stat;

	ede_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.kind      (item.kind),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ede_dp #(
		.MAX_FIRST  (MAX_FIRST),
		.MAX_SECOND (MAX_SECOND)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.symbol   (item.symbol),
		.stat     (stat),
		.distance (result.distance),
		.overflow (result.overflow)
	);

endmodule

`default_nettype wire

>>> bench/tb_edit_distance_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_edit_distance_engine_unit
// Self-checking bench for the edit distance engine. Strings are loaded item
// by item, and the distance and overflow flag of each run are predicted by an
// in-bench row-by-row dynamic program and checked in order. Directed cases,
// full stores, random string pairs under several idle and stall mixes, and a
// long output hold-off are covered.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_edit_distance_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ede_pkg::*;

	localparam int CAP_FIRST   = MAX_FIRST_DEF;
	localparam int CAP_SECOND  = MAX_SECOND_DEF;
	localparam int STUCK_LIMIT = 20000;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} ede_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ede_in_if  in_ch ();
	ede_out_if out_ch ();

	edit_distance_engine_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [SYM_W-1:0] first_syms [CAP_FIRST];
	logic [SYM_W-1:0] second_syms [CAP_SECOND];
	int               first_len;
	int               second_len;
	bit               drop_seen;
	ede_result_t      expected_results [$];

	int          mismatch_count;
	int          loaded_items;
	int          idle_pct;
	int          stall_pct;
	int          hold_left;
	int          stuck_cycles;
	ede_result_t oldest;

	function automatic logic [DIST_W-1:0] edit_distance();
		int row [CAP_SECOND+1];
		int diag;
		int above;
		int cost;
		for (int c = 0; c <= second_len; c++)
			row[c] = c;
		for (int r = 1; r <= first_len; r++) begin
			diag = row[0];
			row[0] = r;
			for (int c = 1; c <= second_len; c++) begin
				above = row[c];
				if (first_syms[r-1] == second_syms[c-1]) begin
					cost = diag;
				end else begin
					cost = (above < row[c-1]) ? above + 1 : row[c-1] + 1;
					cost = (diag + 1 < cost) ? diag + 1 : cost;
				end
				diag = above;
				row[c] = cost;
			end
		end
		if (row[second_len] > int'(DIST_MAX))
			return DIST_MAX;
		return DIST_W'(row[second_len]);
	endfunction

	function automatic void track_item(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s);
		ede_result_t want;
		case (k)
			KIND_FIRST: begin
				loaded_items++;
				if (first_len < CAP_FIRST) begin
					first_syms[first_len] = s;
					first_len++;
				end else begin
					drop_seen = 1'b1;
				end
			end
			KIND_SECOND: begin
				loaded_items++;
				if (second_len < CAP_SECOND) begin
					second_syms[second_len] = s;
					second_len++;
				end else begin
					drop_seen = 1'b1;
				end
			end
			KIND_RUN: begin
				loaded_items++;
				want.distance = edit_distance();
				want.overflow = drop_seen;
				expected_results.push_back(want);
				first_len = 0;
				second_len = 0;
				drop_seen = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [SYM_W-1:0] pick_symbol(bit narrow);
		return narrow ? SYM_W'(8'h61 + $urandom_range(3)) : SYM_W'($urandom_range(255));
	endfunction

	// entered and left at a falling edge; valid stays high after the item
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid  <= 1'b0;
			in_ch.kind   <= KIND_W'($urandom_range(3));
			in_ch.symbol <= SYM_W'($urandom_range(255));
			@(negedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.kind   <= k;
		in_ch.symbol <= s;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		track_item(k, s);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_pair();
		logic [SYM_W-1:0] a [$];
		logic [SYM_W-1:0] b [$];
		int  n1;
		int  n2;
		int  i;
		int  j;
		bit  narrow;
		narrow = 1'($urandom_range(1));
		n1 = ($urandom_range(15) == 0) ? $urandom_range(70) : $urandom_range(10);
		for (i = 0; i < n1; i++)
			a.push_back(pick_symbol(narrow));
		if ($urandom_range(1)) begin
			// second string as an edited copy of the first
			foreach (a[k]) begin
				case ($urandom_range(9))
					0: ;
					1: b.push_back(pick_symbol(narrow));
					2: begin
						b.push_back(a[k]);
						b.push_back(pick_symbol(narrow));
					end
					default: b.push_back(a[k]);
				endcase
			end
		end else begin
			n2 = ($urandom_range(15) == 0) ? $urandom_range(70) : $urandom_range(10);
			for (j = 0; j < n2; j++)
				b.push_back(pick_symbol(narrow));
		end
		i = 0;
		j = 0;
		while (i < a.size() || j < b.size()) begin
			if ($urandom_range(24) == 0)
				send_item(KIND_UNUSED, pick_symbol(1'b0));
			if (j >= b.size() || (i < a.size() && $urandom_range(1))) begin
				send_item(KIND_FIRST, a[i]);
				i++;
			end else begin
				send_item(KIND_SECOND, b[j]);
				j++;
			end
		end
		send_item(KIND_RUN, pick_symbol(1'b0));
	endtask

	task automatic test_directed_cases();
		idle_pct = 0;
		stall_pct = 0;
		send_item(KIND_RUN, 8'h00);
		send_item(KIND_FIRST, 8'h00);
		send_item(KIND_RUN, 8'hFF);
		send_item(KIND_SECOND, 8'hFF);
		send_item(KIND_RUN, 8'h00);
		send_item(KIND_FIRST, 8'hAA);
		send_item(KIND_SECOND, 8'hAA);
		send_item(KIND_RUN, 8'h55);
		send_item(KIND_FIRST, 8'h55);
		send_item(KIND_SECOND, 8'hAA);
		send_item(KIND_RUN, 8'hAA);
		send_item(KIND_UNUSED, 8'hFF);
		send_item(KIND_FIRST, 8'h61);
		send_item(KIND_FIRST, 8'h62);
		send_item(KIND_FIRST, 8'h63);
		send_item(KIND_UNUSED, 8'h00);
		send_item(KIND_SECOND, 8'h61);
		send_item(KIND_SECOND, 8'h63);
		send_item(KIND_RUN, 8'h00);
		send_item(KIND_FIRST, 8'h61);
		send_item(KIND_SECOND, 8'h78);
		send_item(KIND_SECOND, 8'h61);
		send_item(KIND_RUN, 8'hFF);
		wait_drained();
	endtask

	task automatic test_full_stores();
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < CAP_FIRST + 3; i++)
			send_item(KIND_FIRST, pick_symbol(1'b0));
		for (int i = 0; i < CAP_SECOND + 2; i++)
			send_item(KIND_SECOND, pick_symbol(1'b0));
		send_item(KIND_RUN, 8'h00);
		for (int i = 0; i < CAP_FIRST; i++)
			send_item(KIND_FIRST, pick_symbol(1'b1));
		send_item(KIND_RUN, 8'h00);
		for (int i = 0; i < CAP_SECOND + 1; i++)
			send_item(KIND_SECOND, pick_symbol(1'b1));
		send_item(KIND_RUN, 8'h00);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int send_idle, input int recv_stall,
			input int count);
		int start;
		idle_pct = send_idle;
		stall_pct = recv_stall;
		start = loaded_items;
		while (loaded_items - start < count)
			send_pair();
		wait_drained();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 500;
		for (int p = 0; p < 6; p++)
			send_pair();
		wait_drained();
	endtask

	// output ready, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: distance %0d overflow %0d",
					out_ch.distance, out_ch.overflow);
				mismatch_count++;
			end else begin
				oldest = expected_results.pop_front();
				if (out_ch.distance !== oldest.distance) begin
					$error("distance: expected %0d, actual %0d",
						oldest.distance, out_ch.distance);
					mismatch_count++;
				end
				if (out_ch.overflow !== oldest.overflow) begin
					$error("overflow: expected %0d, actual %0d",
						oldest.overflow, out_ch.overflow);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
					(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_FIRST;
		in_ch.symbol = '0;
		out_ch.ready = 1'b0;
		first_len = 0;
		second_len = 0;
		drop_seen = 1'b0;
		mismatch_count = 0;
		loaded_items = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_full_stores();
		test_random_traffic(0, 0, 50);
		test_random_traffic(72, 0, 50);
		test_random_traffic(0, 72, 50);
		test_random_traffic(37, 37, 50);
		test_backpressure();

		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
sv/ede_pkg.sv
sv/ede_if.sv
sv/ede_ctrl.sv
sv/ede_dp.sv
sv/edit_distance_engine_unit.sv
bench/tb_edit_distance_engine_unit.sv
